[rtl/csvs_pkg.sv]
package csvs_pkg;

  localparam int FRAME_W = 6;
  localparam int MASK_W  = 64;
  localparam int COUNT_W = 7;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [COUNT_W-1:0] FRAMES_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]         operation;
    logic [FRAME_W-1:0] frame_index;
    logic [MASK_W-1:0]  eligible_mask;
  } cmd_t;

  typedef struct packed {
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;
  } result_t;

endpackage

[rtl/clock_second_chance_victim_select_unit.sv]
// Channel   Handshake                 Payload             Width
// -------   ------------------------  ------------------  -----
// command   start & !busy accepts     cmd      (cmd_t)    72
// result    result_valid, one cycle   result   (result_t) 7
// config    cfg_write                 cfg_wdata           7
//
// Access and clear finish at the accepting edge; busy stays low and no beat
// comes out. Select scans one frame per cycle through the reference bit
// vector, from the hand, over at most n frames (n = frames in use); the result
// beat shows in the cycle after the last scan step, and a new command may be
// accepted in that same cycle. Reset (rst, synchronous) clears all reference
// bits and the hand and sets frames in use to 64. The receiver cannot stall
// the result beat.
module clock_second_chance_victim_select_unit
  import csvs_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output logic               result_valid,
  output result_t            result,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state;
  logic [COUNT_W-1:0]    frames_in_use;
  logic [MAX_FRAMES-1:0] ref_bits;
  logic [IW-1:0]         hand;
  logic [IW-1:0]         cur;
  logic [CW-1:0]         count;
  logic [MAX_FRAMES-1:0] mask;
  logic                  first_found;
  logic [IW-1:0]         first_idx;

  logic [CW-1:0]         n_frames;
  logic [IW-1:0]         scan_start;
  logic                  accept;
  logic                  elig;
  logic                  hit_clear;
  logic                  hit_set;
  logic                  last_step;
  logic                  done;
  logic                  found;
  logic [IW-1:0]         victim;

  // Step an index forward, wrapping at the frames in use.
  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] v,
                                               input logic [CW-1:0] lim);
    logic [CW-1:0] sum;
    sum = CW'(v) + CW'(1);
    return (sum < lim) ? IW'(sum) : '0;
  endfunction

  // Clamp the register to 1..MAX_FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      n_frames = CW'(1);
    end else if (frames_in_use > COUNT_W'(MAX_FRAMES)) begin
      n_frames = CW'(MAX_FRAMES);
    end else begin
      n_frames = CW'(frames_in_use);
    end
  end

  // A hand left beyond a shrunken pool restarts at frame 0.
  assign scan_start = (CW'(hand) < n_frames) ? hand : '0;

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;

  // Scan step: look at the one frame under the cursor.
  assign elig      = mask[cur];
  assign hit_clear = elig && !ref_bits[cur];
  assign hit_set   = elig && ref_bits[cur];
  assign last_step = ((count + CW'(1)) == n_frames);

  always_comb begin
    done   = 1'b0;
    found  = 1'b0;
    victim = cur;
    if (state == S_SCAN) begin
      if (hit_clear) begin
        // Eligible with a clear bit: this is the victim.
        done  = 1'b1;
        found = 1'b1;
      end else if (last_step) begin
        // Every eligible frame got its second chance; take the first one.
        done = 1'b1;
        if (first_found) begin
          found  = 1'b1;
          victim = first_idx;
        end else if (hit_set) begin
          found = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_write) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Control: sequencer, hand and reference bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hand         <= '0;
      ref_bits     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.operation)
              OP_ACCESS: begin
                if ({1'b0, cmd.frame_index} < COUNT_W'(n_frames)) begin
                  ref_bits[cmd.frame_index[IW-1:0]] <= 1'b1;
                end
              end
              OP_SELECT: begin
                state <= S_SCAN;
              end
              OP_CLEAR: begin
                ref_bits <= '0;
                hand     <= '0;
              end
              default: begin
                // no-op code: drop it
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit_set) begin
            ref_bits[cur] <= 1'b0;
          end
          if (done) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
            if (found) begin
              hand <= wrap_next(victim, n_frames);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: cursor, step count, captured mask, first eligible frame.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cur         <= scan_start;
      count       <= '0;
      first_found <= 1'b0;
      mask        <= cmd.eligible_mask[MAX_FRAMES-1:0];
    end else begin
      cur   <= wrap_next(cur, n_frames);
      count <= count + CW'(1);
      if (hit_set && !first_found) begin
        first_found <= 1'b1;
        first_idx   <= cur;
      end
    end
  end

  // Hold the result beat; zero frame when nothing was eligible.
  always_ff @(posedge clk) begin
    if (done) begin
      result.victim_found <= found;
      result.victim_frame <= found ? FRAME_W'(victim) : '0;
    end
  end

endmodule

[rtl/csvs_checker.sv]
module csvs_checker
  import csvs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input cmd_t               cmd,
  input logic               result_valid,
  input result_t            result
);

  // An accepted select sends the unit busy into a scan.
  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.operation == OP_SELECT) |=> busy)
    else $error("select accepted but unit not busy");

  // Access, clear and no-op never produce a beat and finish at once.
  a_no_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.operation != OP_SELECT) |=> !busy && !result_valid)
    else $error("non-select command produced a beat or stalled");

  // The beat comes with the scan finished.
  a_beat_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result beat while still scanning");

  // Beats are single-cycle strobes, never back to back.
  a_beat_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beats back to back");

  // No victim reports frame zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.victim_found |-> (result.victim_frame == '0))
    else $error("not-found beat with nonzero frame");

endmodule

bind clock_second_chance_victim_select_unit csvs_checker u_csvs_checker (.*);

[test/clock_second_chance_victim_select_unit_tb.sv]
module clock_second_chance_victim_select_unit_tb;
  import csvs_pkg::*;

  localparam int unsigned MAX_FRAMES  = 64;
  // Settle time after the bench goes quiet, well past the longest select.
  localparam int unsigned SETTLE      = 2 * MAX_FRAMES + 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  cmd_t                cmd = '0;
  logic                result_valid;
  result_t             result;
  logic                cfg_write = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  // Shadow of the policy state, advanced as each command beat is taken.
  logic [MASK_W-1:0]   second_chance_bits = '0;
  logic [FRAME_W-1:0]  clock_hand = '0;
  logic [COUNT_W-1:0]  frames_cfg = FRAMES_RESET;

  cmd_t                cmd_backlog[$];
  result_t             pending_victims[$];
  int unsigned         cmds_issued = 0;
  int unsigned         cmds_taken = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;
  int unsigned         idle_pct = 0;

  clock_second_chance_victim_select_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Effective pool size: zero counts as one frame, anything past the
  // maximum saturates.
  function automatic int unsigned frames_active();
    int unsigned n;
    n = frames_cfg;
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  // Apply one command to the shadow state; return 1 when a result beat is due.
  function automatic bit clock_policy_step(input cmd_t c, output result_t victim);
    int unsigned n;
    int unsigned from;
    int unsigned cur;
    victim = '0;
    n = frames_active();
    case (c.operation)
      OP_ACCESS: begin
        // Touches beyond the pool are dropped.
        if (c.frame_index < n) second_chance_bits[c.frame_index] = 1'b1;
        return 1'b0;
      end
      OP_CLEAR: begin
        second_chance_bits = '0;
        clock_hand = '0;
        return 1'b0;
      end
      OP_SELECT: ;
      default: return 1'b0;
    endcase
    // A hand left stranded by a shrink restarts at frame zero.
    from = (clock_hand < n) ? clock_hand : 0;
    // First pass: strip reference bits, stop at the first unreferenced eligible frame.
    cur = from;
    for (int k = 0; k < n; k++) begin
      if (c.eligible_mask[cur]) begin
        if (second_chance_bits[cur]) begin
          second_chance_bits[cur] = 1'b0;
        end else begin
          clock_hand = FRAME_W'((cur + 1 < n) ? cur + 1 : 0);
          victim.victim_found = 1'b1;
          victim.victim_frame = FRAME_W'(cur);
          return 1'b1;
        end
      end
      cur = (cur + 1 < n) ? cur + 1 : 0;
    end
    // Second pass: every eligible frame was referenced, take the first one.
    cur = from;
    for (int k = 0; k < n; k++) begin
      if (c.eligible_mask[cur]) begin
        second_chance_bits[cur] = 1'b0;
        clock_hand = FRAME_W'((cur + 1 < n) ? cur + 1 : 0);
        victim.victim_found = 1'b1;
        victim.victim_frame = FRAME_W'(cur);
        return 1'b1;
      end
      cur = (cur + 1 < n) ? cur + 1 : 0;
    end
    // Nothing eligible: state untouched, not-found beat.
    return 1'b1;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [FRAME_W-1:0] idx,
                           input logic [MASK_W-1:0] mask);
    cmd_t c;
    c.operation     = op;
    c.frame_index   = idx;
    c.eligible_mask = mask;
    cmd_backlog = {cmd_backlog, c};
    cmds_issued++;
  endtask

  // Mostly accesses and selects inside the pool, so reference bits pile up
  // and selects have to hand out second chances; a few clears and no-ops.
  task automatic queue_random_cmd();
    int unsigned         n;
    int unsigned         pick;
    int unsigned         lo;
    int unsigned         hi;
    logic [1:0]          op;
    logic [FRAME_W-1:0]  idx;
    logic [MASK_W-1:0]   mask;
    n    = frames_active();
    pick = $urandom_range(99);
    if (pick < 50)      op = OP_ACCESS;
    else if (pick < 93) op = OP_SELECT;
    else if (pick < 96) op = OP_CLEAR;
    else                op = OP_NOP;
    idx = FRAME_W'(($urandom_range(3) != 0) ? $urandom_range(n - 1) : $urandom_range(63));
    case ($urandom_range(6))
      0: mask = {$urandom, $urandom};
      1: mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: mask = {$urandom, $urandom} | {$urandom, $urandom};
      3: mask = '1;
      4: mask = 64'd1 << $urandom_range(n - 1);
      5: begin
        lo = $urandom_range(63);
        hi = $urandom_range(63);
        mask = '0;
        for (int i = 0; i < MASK_W; i++) mask[i] = (i >= lo && i <= hi) || (i <= lo && i >= hi);
      end
      default: mask = ($urandom_range(1) != 0) ? '0 : {$urandom, $urandom};
    endcase
    queue_cmd(op, idx, mask);
  endtask

  // Block until every command beat is taken, every victim beat is back and
  // the scanner is idle; then settle.
  task automatic wait_quiet();
    while (cmds_taken != cmds_issued || pending_victims.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Reprogram the pool size while idle, set the sender pacing, load commands.
  task automatic run_phase(input logic [COUNT_W-1:0] frames, input int unsigned idle,
                           input int unsigned count);
    wait_quiet();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= frames;
    @(posedge clk);
    cfg_write <= 1'b0;
    frames_cfg = frames;
    idle_pct   = idle;
    repeat (count) queue_random_cmd();
  endtask

  // Driver: hold a beat while busy, otherwise advance to the next command
  // or idle according to the current pacing.
  always @(posedge clk) begin : drive_cmd
    result_t victim;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (clock_policy_step(cmd, victim)) pending_victims = {pending_victims, victim};
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          cmd   <= cmd_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat must match the oldest predicted victim.
  always @(posedge clk) begin : check_victim
    result_t want;
    if (!rst && result_valid) begin
      if (pending_victims.size() == 0) begin
        $display("%0t: unexpected result beat found=%0b frame=%0d", $time,
                 result.victim_found, result.victim_frame);
        mismatches++;
      end else begin
        want = pending_victims.pop_front();
        if (result.victim_found !== want.victim_found) begin
          $display("%0t: victim_found expected %0b got %0b", $time,
                   want.victim_found, result.victim_found);
          mismatches++;
        end
        if (result.victim_frame !== want.victim_frame) begin
          $display("%0t: victim_frame expected %0d got %0d", $time,
                   want.victim_frame, result.victim_frame);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Full pool, no idling, directed corners first.
    run_phase(7'd64, 0, 0);
    queue_cmd(OP_SELECT, 6'd0, '0);                 // nothing eligible
    queue_cmd(OP_ACCESS, 6'd0, '0);
    queue_cmd(OP_ACCESS, 6'd63, '1);
    queue_cmd(OP_ACCESS, 6'd5, '0);
    queue_cmd(OP_SELECT, 6'd0, '1);                 // skip referenced frame zero
    queue_cmd(OP_SELECT, 6'd0, 64'h8000_0000_0000_0000); // lone referenced frame
    queue_cmd(OP_SELECT, 6'd63, 64'h21);
    queue_cmd(OP_ACCESS, 6'd0, '1);
    queue_cmd(OP_SELECT, 6'd0, 64'h21);             // all eligible referenced
    queue_cmd(OP_NOP, 6'd63, '1);
    queue_cmd(OP_CLEAR, 6'd42, '1);
    queue_cmd(OP_SELECT, 6'd0, 64'h1);
    queue_cmd(OP_SELECT, 6'd0, '1);
    queue_cmd(OP_ACCESS, 6'd63, '0);
    queue_cmd(OP_SELECT, 6'd0, 64'h8000_0000_0000_0001);
    queue_cmd(OP_SELECT, 6'd0, '1);
    repeat (150) queue_random_cmd();

    // Walk the pool size through its corners and pacing modes. Shrinking
    // after a full pool strands the hand past the end.
    run_phase(7'd1, 82, 60);
    run_phase(7'd0, 0, 60);
    run_phase(7'd127, 22, 150);
    run_phase(7'd5, 82, 120);
    run_phase(7'd2, 0, 80);
    run_phase(7'd65, 22, 100);
    run_phase(7'd40, 82, 100);
    run_phase(7'($urandom_range(127)), 0, 100);
    run_phase(7'd64, 22, 100);

    wait_quiet();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/csvs_pkg.sv
rtl/clock_second_chance_victim_select_unit.sv
rtl/csvs_checker.sv
test/clock_second_chance_victim_select_unit_tb.sv
